// ----- src/strrot_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and controller/datapath interface types for the string rotation check.
// No dependencies.
package strrot_pkg;

    localparam int MAX_LEN = 128;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int IDX_W   = $clog2(MAX_LEN);

    localparam logic FUNC_FIRST  = 1'b0;
    localparam logic FUNC_SECOND = 1'b1;

    typedef struct packed {
        logic load;      // accepted input word
        logic init;      // start a search at rotation 0
        logic step_i;    // next byte of the current rotation
        logic step_k;    // next rotation
        logic set_rot;   // rotation found
        logic res_load;  // move pending result to output register
    } strrot_cmd_t;

    typedef struct packed {
        logic quick_fail; // result known without a search
        logic eq;         // compared bytes match
        logic i_last;
        logic k_last;
        logic out_free;
    } strrot_status_t;

endpackage

// ----- src/strrot_dp.sv -----
`timescale 1ns / 1ps
// Datapath: string stores, lengths, search counters and the output register.
// Depends on strrot_pkg.
module strrot_dp
    import strrot_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  strrot_cmd_t    cmd,
    output strrot_status_t status,
    input  logic           func,
    input  logic [7:0]     ch,
    input  logic           last,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata
);

    logic [7:0] first_mem  [MAX_LEN];
    logic [7:0] second_mem [MAX_LEN];

    logic [LEN_W-1:0] first_len_reg, first_len_next;
    logic             first_over_reg, first_over_next;
    logic             first_closed_reg, first_closed_next;
    logic [LEN_W-1:0] second_len_reg, second_len_next;
    logic             second_over_reg, second_over_next;

    logic [IDX_W-1:0] k_reg, i_reg, j_reg, last_idx_reg;
    logic [7:0]       first_q_reg, second_q_reg;
    logic             rot_reg, tl_reg;
    logic             out_valid_reg, out_rot_reg, out_tl_reg;

    logic [LEN_W-1:0] f_base;
    logic             f_room, s_room;
    logic [LEN_W-1:0] sec_len_new;
    logic             sec_over_new;
    logic             too_long_now;
    logic             wr_first, wr_second;

    always_comb
    begin
        f_base       = first_closed_reg ? '0 : first_len_reg;
        f_room       = f_base < LEN_W'(MAX_LEN);
        s_room       = second_len_reg < LEN_W'(MAX_LEN);
        sec_len_new  = second_len_reg + LEN_W'(s_room);
        sec_over_new = second_over_reg | ~s_room;
        too_long_now = first_over_reg | sec_over_new;
        wr_first     = cmd.load && (func == FUNC_FIRST) && f_room;
        wr_second    = cmd.load && (func == FUNC_SECOND) && s_room;

        first_len_next    = first_len_reg;
        first_over_next   = first_over_reg;
        first_closed_next = first_closed_reg;
        second_len_next   = second_len_reg;
        second_over_next  = second_over_reg;
        if (cmd.load)
        begin
            if (func == FUNC_FIRST)
            begin
                first_len_next    = f_base + LEN_W'(f_room);
                first_over_next   = (first_closed_reg ? 1'b0 : first_over_reg) | ~f_room;
                first_closed_next = last;
            end
            else if (last)
            begin
                second_len_next  = '0;
                second_over_next = 1'b0;
            end
            else
            begin
                second_len_next  = sec_len_new;
                second_over_next = sec_over_new;
            end
        end

        status.quick_fail = too_long_now || (first_len_reg == '0)
                            || (first_len_reg != sec_len_new);
        status.eq         = first_q_reg == second_q_reg;
        status.i_last     = i_reg == last_idx_reg;
        status.k_last     = k_reg == last_idx_reg;
        status.out_free   = ~out_valid_reg | m_tready;
    end

    // stores: one write and one registered read per cycle each
    always_ff @(posedge clk)
    begin
        if (wr_first)
        begin
            first_mem[f_base[IDX_W-1:0]] <= ch;
        end
        first_q_reg <= first_mem[j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (wr_second)
        begin
            second_mem[second_len_reg[IDX_W-1:0]] <= ch;
        end
        second_q_reg <= second_mem[i_reg];
    end

    // search counters; j tracks (i + k) mod n
    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            k_reg        <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            last_idx_reg <= IDX_W'(first_len_reg - LEN_W'(1));
        end
        else if (cmd.step_i)
        begin
            i_reg <= i_reg + IDX_W'(1);
            j_reg <= (j_reg == last_idx_reg) ? '0 : j_reg + IDX_W'(1);
        end
        else if (cmd.step_k)
        begin
            k_reg <= k_reg + IDX_W'(1);
            i_reg <= '0;
            j_reg <= k_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && (func == FUNC_SECOND) && last)
        begin
            tl_reg  <= too_long_now;
            rot_reg <= 1'b0;
        end
        else if (cmd.set_rot)
        begin
            rot_reg <= 1'b1;
        end
        if (cmd.res_load)
        begin
            out_rot_reg <= rot_reg;
            out_tl_reg  <= tl_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_len_reg    <= '0;
            first_over_reg   <= 1'b0;
            first_closed_reg <= 1'b0;
            second_len_reg   <= '0;
            second_over_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            first_len_reg    <= first_len_next;
            first_over_reg   <= first_over_next;
            first_closed_reg <= first_closed_next;
            second_len_reg   <= second_len_next;
            second_over_reg  <= second_over_next;
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_tl_reg, out_rot_reg};

endmodule

// ----- src/strrot_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine: input handshake and sequencing of the rotation search.
// Depends on strrot_pkg.
module strrot_ctrl
    import strrot_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic           func,
    input  logic           last,
    input  strrot_status_t status,
    output strrot_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_CMP  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       accept;

    always_comb
    begin
        s_tready   = state_reg == ST_IDLE;
        accept     = s_tvalid & s_tready;
        cmd        = '0;
        cmd.load   = accept;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (func == FUNC_SECOND) && last)
                begin
                    if (status.quick_fail)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        cmd.init   = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (status.eq)
                begin
                    if (status.i_last)
                    begin
                        cmd.set_rot = 1'b1;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        cmd.step_i = 1'b1;
                        state_next = ST_READ;
                    end
                end
                else if (status.k_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.step_k = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/string_rotation_check.sv -----
`timescale 1ns / 1ps
// Top level of the string rotation check: controller plus datapath.
// Depends on strrot_pkg, strrot_ctrl, strrot_dp.
//
//  bus     dir  contents
//  s_*     in   tdata[7:0] = ch, tuser[0] = func (0 first, 1 second), tlast = last
//  m_*     out  tdata[0] = is_rotation, tdata[1] = too_long, tdata[7:2] = 0
//
// Input words are taken only while the controller is idle. After the last word of the
// second string the search compares one byte pair per READ and CMP state pair
// (registered store reads); length or overflow failures go straight to the done state.
// rst_n clears lengths, flags and the state machine; string stores are not cleared.
// A pending result waits in the output register; loading continues while it waits.
module string_rotation_check
    import strrot_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // ch
    input  logic [0:0] s_tuser,   // func
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // is_rotation, too_long, zero fill
);

    strrot_cmd_t    cmd;
    strrot_status_t status;

    strrot_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .func     (s_tuser[0]),
        .last     (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    strrot_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .func     (s_tuser[0]),
        .ch       (s_tdata),
        .last     (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
